// ===== hw/rtl/rgbf_pkg.sv =====
// Shared types and constants for the RGB eased colour fader.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package rgbf_pkg;

    localparam int TIME_BITS   = 32;
    localparam int FADE_BITS   = 16;
    localparam int RESET_LEVEL = 50;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_COLOUR = 1'b1;

    localparam logic [1:0] FIRST_CHAN = 2'd0;
    localparam logic [1:0] LAST_CHAN  = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_SQR   = 9'b000000100,
        S_DEN   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIVGO = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_STORE = 9'b010000000,
        S_DONE  = 9'b100000000
    } ctrl_state_t;

    typedef struct packed {
        logic       capture;
        logic       do_cmd;
        logic       do_snap;
        logic       do_prep;
        logic       do_square;
        logic       do_den;
        logic       do_mul;
        logic       div_start;
        logic       do_store;
        logic       do_out;
        logic [1:0] chan;
    } dp_cmd_t;

    typedef struct packed {
        logic is_colour;
        logic differs;
        logic snap;
        logic div_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_eased_color_fader.sv =====
// RGB eased colour fader: one result per input item, valid/ready on both sides.
// A colour command, an idle tick or a tick that snaps to the target runs from capture
// through the execute state to the output register; an easing tick adds the square,
// denominator, multiply, divider and store states, the last three for red, green and
// blue in turn; the shared restoring divider produces one quotient bit per cycle. The
// input is taken only while the controller is idle, but a finished result waiting in
// the output register does not block the next input transfer. Each easing tick computes
// start + diff*e^2/(e^2+r^2) per channel exactly (floor for rising channels, ceiling of
// the step for falling ones), with e and r the elapsed and remaining milliseconds; past
// the end time, or with a zero fade length, the colour snaps to the target. Colour and
// level ports are CHANNEL_BITS wide; after reset every channel sits at 50, or at full
// scale where 50 does not fit.
// Depends on rgbf_pkg, rgbf_ctrl, rgbf_dp and rgbf_div.
`default_nettype none

module rgb_eased_color_fader #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic [rgbf_pkg::TIME_BITS-1:0]    s_now_ms,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_red,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_green,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_blue,
    input  wire logic [rgbf_pkg::FADE_BITS-1:0]    s_fade_ms,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [CHANNEL_BITS-1:0]           m_red_level,
    output logic      [CHANNEL_BITS-1:0]           m_green_level,
    output logic      [CHANNEL_BITS-1:0]           m_blue_level,
    output logic                                   m_fading
);

    rgbf_pkg::dp_cmd_t  cmd;
    rgbf_pkg::dp_stat_t stat;

    // Controller: one-hot sequencer, channel counter and output valid flag
    rgbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: captured item, colour state, squares, product, divider, output register
    rgbf_dp #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_mode        (s_mode),
        .s_now_ms      (s_now_ms),
        .s_cmd_red     (s_cmd_red),
        .s_cmd_green   (s_cmd_green),
        .s_cmd_blue    (s_cmd_blue),
        .s_fade_ms     (s_fade_ms),
        .cmd           (cmd),
        .stat          (stat),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_fading      (m_fading)
    );

`ifndef SYNTHESIS
    // An input transfer starts work: the input side must close on the next cycle
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after a transfer");

    // Starting the divider must make it busy on the next cycle
    a_div_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not start");

    // Never store a channel level while the divider is still iterating
    a_store_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_store |-> !stat.div_busy)
        else $error("channel stored while divider busy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rgbf_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
// Depends on nothing; instantiated by rgbf_dp.
`default_nettype none

module rgbf_div #(
    parameter int QUO_BITS = 8,
    parameter int DIV_BITS = 33
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [QUO_BITS+DIV_BITS-2:0]      dividend,
    input  wire logic [DIV_BITS-1:0]               divisor,
    output logic      [QUO_BITS-1:0]               quotient,
    output logic      [DIV_BITS-1:0]               remainder,
    output logic                                   busy
);

    localparam int NUM_BITS = QUO_BITS + DIV_BITS - 1;
    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [DIV_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0] low_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;

    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS:0]   trial_sub;
    logic                ge;

    // Shift in the next dividend bit; subtract when the divisor fits.
    assign trial     = {rem_reg, low_reg[QUO_BITS-1]};
    assign ge        = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(QUO_BITS);
        end else if (busy_reg) begin
            busy_reg <= (cnt_reg != CNT_BITS'(1));
            cnt_reg  <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend[NUM_BITS-1:QUO_BITS]};
            low_reg <= dividend[QUO_BITS-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            low_reg <= {low_reg[QUO_BITS-2:0], ge};
        end
    end

    assign quotient  = low_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rgbf_dp.sv =====
// Datapath of the fader: colour state, time arithmetic, squares, product and divider.
// Depends on rgbf_pkg and rgbf_div; driven by commands from rgbf_ctrl.
`default_nettype none

module rgbf_dp #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_mode,
    input  wire logic [rgbf_pkg::TIME_BITS-1:0]    s_now_ms,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_red,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_green,
    input  wire logic [CHANNEL_BITS-1:0]           s_cmd_blue,
    input  wire logic [rgbf_pkg::FADE_BITS-1:0]    s_fade_ms,
    input  wire rgbf_pkg::dp_cmd_t                 cmd,
    output rgbf_pkg::dp_stat_t                     stat,
    output logic      [CHANNEL_BITS-1:0]           m_red_level,
    output logic      [CHANNEL_BITS-1:0]           m_green_level,
    output logic      [CHANNEL_BITS-1:0]           m_blue_level,
    output logic                                   m_fading
);

    localparam int CB        = CHANNEL_BITS;
    localparam int TB        = rgbf_pkg::TIME_BITS;
    localparam int FB        = rgbf_pkg::FADE_BITS;
    localparam int SQ_BITS   = 2 * FB;
    localparam int DEN_BITS  = SQ_BITS + 1;
    localparam int PROD_BITS = CB + SQ_BITS;
    localparam int CHAN_MAX  = (2 ** CB) - 1;
    localparam logic [CB-1:0] RESET_VALUE =
        (rgbf_pkg::RESET_LEVEL > CHAN_MAX) ? CB'(CHAN_MAX) : CB'(rgbf_pkg::RESET_LEVEL);

    // Captured input item
    logic          mode_reg;
    logic [TB-1:0] now_reg;
    logic [CB-1:0] col_reg [3];
    logic [FB-1:0] dur_reg;

    // Fader state
    logic [CB-1:0] cur_reg   [3];
    logic [CB-1:0] start_reg [3];
    logic [CB-1:0] tgt_reg   [3];
    logic [TB-1:0] end_reg;
    logic [FB-1:0] flen_reg;

    // Easing intermediates
    logic [FB-1:0]        rem_reg;
    logic [FB-1:0]        ela_reg;
    logic [SQ_BITS-1:0]   num_reg;
    logic [SQ_BITS-1:0]   rsq_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic [PROD_BITS-1:0] prod_reg;

    // Output register
    logic [CB-1:0] red_reg;
    logic [CB-1:0] green_reg;
    logic [CB-1:0] blue_reg;
    logic          fading_reg;

    logic          differs;
    logic          col_match;
    logic [TB-1:0] past;
    logic [TB-1:0] rem_full;
    logic [FB-1:0] rem_clamp;
    logic [CB-1:0] from_lvl;
    logic [CB-1:0] to_lvl;
    logic          up;
    logic [CB-1:0] mag;
    logic [CB-1:0] quo;
    logic [DEN_BITS-1:0] rmd;
    logic          div_busy;
    logic [CB-1:0] step_dn;
    logic [CB-1:0] level;

    assign differs   = (cur_reg[0] != tgt_reg[0]) || (cur_reg[1] != tgt_reg[1]) ||
                       (cur_reg[2] != tgt_reg[2]);
    assign col_match = (col_reg[0] == tgt_reg[0]) && (col_reg[1] == tgt_reg[1]) &&
                       (col_reg[2] == tgt_reg[2]);

    // Wrap-safe end-of-fade test: strictly past the end time
    assign past      = now_reg - end_reg;
    assign rem_full  = end_reg - now_reg;
    assign rem_clamp = (rem_full > TB'(flen_reg)) ? flen_reg : rem_full[FB-1:0];

    assign from_lvl = start_reg[cmd.chan];
    assign to_lvl   = tgt_reg[cmd.chan];
    assign up       = to_lvl >= from_lvl;
    assign mag      = up ? (to_lvl - from_lvl) : (from_lvl - to_lvl);
    // Falling channels round the step up, rising ones round down
    assign step_dn  = quo + CB'(rmd != '0);
    assign level    = up ? (from_lvl + quo) : (from_lvl - step_dn);

    assign stat.is_colour = (mode_reg == rgbf_pkg::MODE_COLOUR);
    assign stat.differs   = differs;
    assign stat.snap      = ((past != '0) && !past[TB-1]) || (flen_reg == '0);
    assign stat.div_busy  = div_busy;

    rgbf_div #(
        .QUO_BITS (CB),
        .DIV_BITS (DEN_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (prod_reg),
        .divisor   (den_reg),
        .quotient  (quo),
        .remainder (rmd),
        .busy      (div_busy)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_mode;
            now_reg    <= s_now_ms;
            col_reg[0] <= s_cmd_red;
            col_reg[1] <= s_cmd_green;
            col_reg[2] <= s_cmd_blue;
            dur_reg    <= s_fade_ms;
        end
        if (cmd.do_prep) begin
            rem_reg <= rem_clamp;
            ela_reg <= flen_reg - rem_clamp;
        end
        if (cmd.do_square) begin
            num_reg <= ela_reg * ela_reg;
            rsq_reg <= rem_reg * rem_reg;
        end
        if (cmd.do_den) begin
            den_reg <= {1'b0, num_reg} + {1'b0, rsq_reg};
        end
        if (cmd.do_mul) begin
            prod_reg <= mag * num_reg;
        end
        if (cmd.do_out) begin
            red_reg    <= cur_reg[0];
            green_reg  <= cur_reg[1];
            blue_reg   <= cur_reg[2];
            fading_reg <= differs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                cur_reg[k]   <= RESET_VALUE;
                start_reg[k] <= '0;
                tgt_reg[k]   <= RESET_VALUE;
            end
            end_reg  <= '0;
            flen_reg <= '0;
        end else begin
            if (cmd.do_cmd && !col_match) begin
                if (dur_reg != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        start_reg[k] <= cur_reg[k];
                        tgt_reg[k]   <= col_reg[k];
                    end
                    flen_reg <= dur_reg;
                    end_reg  <= now_reg + TB'(dur_reg);
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        start_reg[k] <= col_reg[k];
                        tgt_reg[k]   <= col_reg[k];
                        cur_reg[k]   <= col_reg[k];
                    end
                    flen_reg <= '0;
                    end_reg  <= now_reg;
                end
            end
            if (cmd.do_snap) begin
                for (int k = 0; k < 3; k++) begin
                    cur_reg[k] <= tgt_reg[k];
                end
            end
            if (cmd.do_store) begin
                cur_reg[cmd.chan] <= level;
            end
        end
    end

    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;
    assign m_fading      = fading_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rgbf_ctrl.sv =====
// Controller of the fader: sequences capture, command, snap and easing steps.
// Depends on rgbf_pkg; drives rgbf_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module rgbf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire rgbf_pkg::dp_stat_t  stat,
    output rgbf_pkg::dp_cmd_t        cmd
);

    rgbf_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]            chan_reg, chan_next;
    logic                  m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.chan     = chan_reg;
        case (state_reg)
            rgbf_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = rgbf_pkg::S_EXEC;
                end
            end
            rgbf_pkg::S_EXEC: begin
                if (stat.is_colour) begin
                    cmd.do_cmd = 1'b1;
                    state_next = rgbf_pkg::S_DONE;
                end else if (!stat.differs) begin
                    state_next = rgbf_pkg::S_DONE;
                end else if (stat.snap) begin
                    cmd.do_snap = 1'b1;
                    state_next  = rgbf_pkg::S_DONE;
                end else begin
                    cmd.do_prep = 1'b1;
                    state_next  = rgbf_pkg::S_SQR;
                end
            end
            rgbf_pkg::S_SQR: begin
                cmd.do_square = 1'b1;
                state_next    = rgbf_pkg::S_DEN;
            end
            rgbf_pkg::S_DEN: begin
                cmd.do_den = 1'b1;
                chan_next  = rgbf_pkg::FIRST_CHAN;
                state_next = rgbf_pkg::S_MUL;
            end
            rgbf_pkg::S_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = rgbf_pkg::S_DIVGO;
            end
            rgbf_pkg::S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = rgbf_pkg::S_DIV;
            end
            rgbf_pkg::S_DIV: begin
                if (!stat.div_busy) begin
                    state_next = rgbf_pkg::S_STORE;
                end
            end
            rgbf_pkg::S_STORE: begin
                cmd.do_store = 1'b1;
                if (chan_reg == rgbf_pkg::LAST_CHAN) begin
                    state_next = rgbf_pkg::S_DONE;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = rgbf_pkg::S_MUL;
                end
            end
            rgbf_pkg::S_DONE: begin
                // hold until the output register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    cmd.do_out   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rgbf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rgbf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rgbf_pkg::S_IDLE;
            chan_reg    <= rgbf_pkg::FIRST_CHAN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == rgbf_pkg::S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for rgb_eased_color_fader: directed table plus random ticks and colour commands.
// Depends on rgbf_pkg and the fader RTL; checks every result against typed-in levels or its own easing predictor.

module tb_top;

    localparam int TIME_BITS = rgbf_pkg::TIME_BITS;
    localparam int FADE_BITS = rgbf_pkg::FADE_BITS;

    // Channel width of the instance under test; the predictor works at the same width.
    localparam int CHAN_BITS     = 8;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1200;
    // Wait after the last expected result so that any late extras show up.
    localparam int DRAIN_CYCLES  = 60;
    // Cycles with no transfer on either side before the run is declared hung.
    localparam int IDLE_LIMIT    = 5000;
    // Results seen before the sink holds off, and how long it holds off.
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 400;

    typedef logic [CHAN_BITS-1:0]      level_t;
    typedef logic [2:0][CHAN_BITS-1:0] colour_t;   // [0] red, [1] green, [2] blue

    typedef struct packed {
        logic                 mode;
        logic [TIME_BITS-1:0] now;
        colour_t              colour;
        logic [FADE_BITS-1:0] fade;
    } fader_in_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
        logic   fading;
    } levels_t;

    // One line of the directed table; where known is set the wanted levels are typed in,
    // otherwise the predictor supplies them.
    typedef struct packed {
        logic                 mode;
        logic [TIME_BITS-1:0] now;
        level_t               red;
        level_t               green;
        level_t               blue;
        logic [FADE_BITS-1:0] fade;
        logic                 known;
        level_t               want_red;
        level_t               want_green;
        level_t               want_blue;
        logic                 want_fading;
    } plan_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports; the driven inputs are known from time zero
    // ------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_mode        = rgbf_pkg::MODE_TICK;
    logic [TIME_BITS-1:0] s_now_ms      = '0;
    level_t               s_cmd_red     = '0;
    level_t               s_cmd_green   = '0;
    level_t               s_cmd_blue    = '0;
    logic [FADE_BITS-1:0] s_fade_ms     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    level_t               m_red_level;
    level_t               m_green_level;
    level_t               m_blue_level;
    logic                 m_fading;

    always #1 aclk = ~aclk;

    rgb_eased_color_fader #(
        .CHANNEL_BITS(CHAN_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_now_ms     (s_now_ms),
        .s_cmd_red    (s_cmd_red),
        .s_cmd_green  (s_cmd_green),
        .s_cmd_blue   (s_cmd_blue),
        .s_fade_ms    (s_fade_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_level  (m_red_level),
        .m_green_level(m_green_level),
        .m_blue_level (m_blue_level),
        .m_fading     (m_fading)
    );

    // ------------------------------------------------------------------
    // Fader predictor: our own copy of the colour state
    // ------------------------------------------------------------------
    colour_t              lvl_now;     // colour driven at present
    colour_t              lvl_from;    // colour at the start of the running fade
    colour_t              lvl_goal;    // commanded target colour
    logic [TIME_BITS-1:0] end_ms;      // time at which the fade completes
    logic [FADE_BITS-1:0] span_ms;     // length of the running fade

    levels_t pending_levels[$];        // expected results, oldest first
    int      fault_count  = 0;
    int      levels_seen  = 0;
    int      items_sent   = 0;
    bit      gappy        = 1'b0;      // sender inserts gaps in the present burst

    function automatic void reset_fader();
        level_t rest;
        rest = (rgbf_pkg::RESET_LEVEL > (2 ** CHAN_BITS - 1)) ?
               '1 : level_t'(rgbf_pkg::RESET_LEVEL);
        lvl_now  = {3{rest}};
        lvl_goal = {3{rest}};
        lvl_from = '0;
        end_ms   = '0;
        span_ms  = '0;
    endfunction

    // Rising channels take the floor of the step; falling channels take its ceiling,
    // so both move by floor/ceil of diff*num/den away from the start level.
    function automatic level_t ease_channel(level_t from_l, level_t to_l,
                                            logic [63:0] num, logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] stp;
        if (to_l >= from_l) begin
            mag = to_l - from_l;
            stp = (mag * num) / den;
            return from_l + level_t'(stp);
        end
        mag = from_l - to_l;
        stp = (mag * num + den - 64'd1) / den;
        return from_l - level_t'(stp);
    endfunction

    // Apply one accepted input to the predictor state and return the levels it should report.
    function automatic levels_t advance_fader(fader_in_t it);
        logic [TIME_BITS-1:0] past;
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] ela;
        logic [63:0]          num;
        logic [63:0]          den;
        levels_t              res;
        int                   k;
        if (it.mode == rgbf_pkg::MODE_COLOUR) begin
            // A command equal to the present target changes nothing.
            if (it.colour != lvl_goal) begin
                if (it.fade != '0) begin
                    lvl_from = lvl_now;
                    lvl_goal = it.colour;
                    span_ms  = it.fade;
                    end_ms   = it.now + it.fade;
                end else begin
                    lvl_from = it.colour;
                    lvl_goal = it.colour;
                    lvl_now  = it.colour;
                    span_ms  = '0;
                    end_ms   = it.now;
                end
            end
        end else if (lvl_now != lvl_goal) begin
            // Wrap-safe compare: past the end when now - end is positive as a signed value.
            past = it.now - end_ms;
            if ((past != '0 && !past[TIME_BITS-1]) || span_ms == '0) begin
                lvl_now = lvl_goal;
            end else begin
                // Clamp the remaining time when time has run backwards.
                rem = end_ms - it.now;
                if (rem > span_ms)
                    rem = span_ms;
                ela = span_ms - rem;
                num = 64'(ela) * 64'(ela);
                den = num + 64'(rem) * 64'(rem);
                for (k = 0; k < 3; k++)
                    lvl_now[k] = ease_channel(lvl_from[k], lvl_goal[k], num, den);
            end
        end
        res.red    = lvl_now[0];
        res.green  = lvl_now[1];
        res.blue   = lvl_now[2];
        res.fading = (lvl_now != lvl_goal);
        return res;
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 2);
        if (roll < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item from a falling edge, hold it until the transfer, then record what
    // it should produce. Returns at the falling edge after the transfer.
    task automatic deliver_item(input fader_in_t it, input bit known, input levels_t want);
        int      gap;
        levels_t model_out;
        // Every 40 items, pick at random whether the next burst is gapped or back-to-back.
        if (items_sent % 40 == 0)
            gappy = ($urandom_range(0, 2) != 0);
        items_sent++;
        gap = (gappy && $urandom_range(0, 1) == 1) ? gap_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= it.mode;
        s_now_ms    <= it.now;
        s_cmd_red   <= it.colour[0];
        s_cmd_green <= it.colour[1];
        s_cmd_blue  <= it.colour[2];
        s_fade_ms   <= it.fade;
        do @(posedge aclk); while (!s_ready);
        model_out = advance_fader(it);
        pending_levels.push_back(known ? want : model_out);
        @(negedge aclk);
    endtask

    function automatic void compare_level(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fault_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table: idle ticks, jumps, ignored commands, fades sampled at the start,
    // the midpoint and the end, time running backwards, wrap of the millisecond
    // counter and the signed-compare boundary, a retarget in mid-fade.
    // ------------------------------------------------------------------
    plan_row_t directed_plan [DIRECTED_ROWS] = '{
        // tick straight after reset: colour fields and duration are ignored
        '{rgbf_pkg::MODE_TICK,   32'd0,          8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
          1'b1, 8'd50,  8'd50,  8'd50,  1'b0},
        // command equal to the target: ignored
        '{rgbf_pkg::MODE_COLOUR, 32'd10,         8'd50, 8'd50, 8'd50, 16'd500,
          1'b1, 8'd50,  8'd50,  8'd50,  1'b0},
        // zero duration: jump at once
        '{rgbf_pkg::MODE_COLOUR, 32'd20,         8'hFF, 8'h00, 8'h80, 16'd0,
          1'b1, 8'hFF,  8'h00,  8'h80,  1'b0},
        // start a fade: colour holds until the next tick
        '{rgbf_pkg::MODE_COLOUR, 32'd1000,       8'h00, 8'hFF, 8'h00, 16'd1000,
          1'b1, 8'hFF,  8'h00,  8'h80,  1'b1},
        '{rgbf_pkg::MODE_TICK,   32'd1000,       8'h00, 8'h00, 8'h00, 16'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{rgbf_pkg::MODE_TICK,   32'd1500,       8'h00, 8'h00, 8'h00, 16'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // exactly at the end time: full step lands on the target
        '{rgbf_pkg::MODE_TICK,   32'd2000,       8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'hFF,  8'h00,  1'b0},
        '{rgbf_pkg::MODE_TICK,   32'd2001,       8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'hFF,  8'h00,  1'b0},
        // longest fade
        '{rgbf_pkg::MODE_COLOUR, 32'd3000,       8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
          1'b1, 8'h00,  8'hFF,  8'h00,  1'b1},
        '{rgbf_pkg::MODE_TICK,   32'd35768,      8'h00, 8'h00, 8'h00, 16'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // time ran backwards: remaining clamps to the fade length, colour is the start
        '{rgbf_pkg::MODE_TICK,   32'd2000,       8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'hFF,  8'h00,  1'b1},
        // one past the end: snap
        '{rgbf_pkg::MODE_TICK,   32'd68536,      8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'hFF,  8'hFF,  8'hFF,  1'b0},
        // end time wraps through zero
        '{rgbf_pkg::MODE_COLOUR, 32'hFFFF_FFF0,  8'h00, 8'h00, 8'h00, 16'h0100,
          1'b1, 8'hFF,  8'hFF,  8'hFF,  1'b1},
        '{rgbf_pkg::MODE_TICK,   32'h0000_0010,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{rgbf_pkg::MODE_TICK,   32'h0000_00F0,  8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'h00,  8'h00,  1'b0},
        // one-millisecond fade ending at 0x80000000
        '{rgbf_pkg::MODE_COLOUR, 32'h7FFF_FFFF,  8'h80, 8'h7F, 8'h01, 16'd1,
          1'b1, 8'h00,  8'h00,  8'h00,  1'b1},
        // half a wrap away from the end: not past, clamps to the start colour
        '{rgbf_pkg::MODE_TICK,   32'h0000_0000,  8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'h00,  8'h00,  1'b1},
        '{rgbf_pkg::MODE_TICK,   32'h8000_0000,  8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h80,  8'h7F,  8'h01,  1'b0},
        '{rgbf_pkg::MODE_COLOUR, 32'd100,        8'hAA, 8'h55, 8'hFF, 16'd0,
          1'b1, 8'hAA,  8'h55,  8'hFF,  1'b0},
        '{rgbf_pkg::MODE_COLOUR, 32'd200,        8'h55, 8'hAA, 8'h00, 16'h8000,
          1'b1, 8'hAA,  8'h55,  8'hFF,  1'b1},
        '{rgbf_pkg::MODE_TICK,   32'd16584,      8'h00, 8'h00, 8'h00, 16'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // retarget in mid-fade: start becomes the present colour
        '{rgbf_pkg::MODE_COLOUR, 32'd16600,      8'h00, 8'hFF, 8'h80, 16'd50,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // repeat of the running target: ignored even with another duration
        '{rgbf_pkg::MODE_COLOUR, 32'd16610,      8'h00, 8'hFF, 8'h80, 16'd9,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{rgbf_pkg::MODE_TICK,   32'd16625,      8'h00, 8'h00, 8'h00, 16'd0,
          1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{rgbf_pkg::MODE_TICK,   32'd16700,      8'h00, 8'h00, 8'h00, 16'd0,
          1'b1, 8'h00,  8'hFF,  8'h80,  1'b0}
    };

    // ------------------------------------------------------------------
    // Result checker: compare every result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        levels_t want;
        if (aresetn && m_valid && m_ready) begin
            levels_seen++;
            if (pending_levels.size() == 0) begin
                $error("result transfer with no expected colour pending");
                fault_count++;
            end else begin
                want = pending_levels.pop_front();
                compare_level("red_level",   want.red,    m_red_level);
                compare_level("green_level", want.green,  m_green_level);
                compare_level("blue_level",  want.blue,   m_blue_level);
                compare_level("fading",      want.fading, m_fading);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side transfers for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls in bursts, and one long hold-off so that the
    // output register fills and the block stalls its input
    // ------------------------------------------------------------------
    initial begin : result_sink
        int burst;
        int stall_left;
        bit stalls_on;
        bit held_off;
        stall_left = 0;
        held_off   = 1'b0;
        @(posedge aresetn);
        forever begin
            stalls_on = ($urandom_range(0, 2) != 0);
            burst     = $urandom_range(20, 120);
            repeat (burst) begin
                @(negedge aclk);
                if (!held_off && levels_seen >= HOLD_AFTER) begin
                    // Hold off while the sender keeps offering items.
                    held_off = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                if (stalls_on && stall_left == 0 && $urandom_range(0, 3) == 0)
                    stall_left = gap_length();
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random ticks and commands
    // ------------------------------------------------------------------
    initial begin : stimulus
        fader_in_t            it;
        levels_t              want;
        logic [TIME_BITS-1:0] clock_ms;
        int                   n;
        int                   k;
        int                   roll;

        reset_fader();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table.
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            it.mode        = directed_plan[n].mode;
            it.now         = directed_plan[n].now;
            it.colour      = {directed_plan[n].blue, directed_plan[n].green,
                              directed_plan[n].red};
            it.fade        = directed_plan[n].fade;
            want.red       = directed_plan[n].want_red;
            want.green     = directed_plan[n].want_green;
            want.blue      = directed_plan[n].want_blue;
            want.fading    = directed_plan[n].want_fading;
            deliver_item(it, directed_plan[n].known, want);
        end

        // Random part: a millisecond clock that mostly creeps forward, with ticks
        // between occasional commands so that fades run, get retargeted and finish.
        // Now and then the clock jumps anywhere or steps back.
        clock_ms = 32'd20000;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_ms = $urandom;
            else if (roll < 6)
                clock_ms = clock_ms - $urandom_range(1, 300);
            else
                clock_ms = clock_ms + $urandom_range(0, 12);
            it.mode   = rgbf_pkg::MODE_TICK;
            it.now    = clock_ms;
            it.colour = colour_t'($urandom);
            it.fade   = FADE_BITS'($urandom);
            if ($urandom_range(0, 99) < 7) begin
                it.mode = rgbf_pkg::MODE_COLOUR;
                roll    = $urandom_range(0, 99);
                if (roll < 12) begin
                    it.colour = lvl_goal;
                end else if (roll < 20) begin
                    for (k = 0; k < 3; k++)
                        it.colour[k] = ($urandom_range(0, 1) == 1) ? '1 : '0;
                end
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    it.fade = '0;
                else if (roll < 88)
                    it.fade = FADE_BITS'($urandom_range(1, 400));
            end
            deliver_item(it, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected result, then let any late extras show up.
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_levels.size() != 0) begin
            $error("%0d expected results never arrived", pending_levels.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
